@@ hw/rtl/ptd_pkg.sv @@
// shared types, constants and register codes for the probability-to-drive block
package ptd_pkg;

    localparam int PROB_W     = 16;
    localparam int DRIVE_W    = 17;
    localparam int TURN_W     = 18;
    localparam int LEVEL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 72;

    // one bit of quotient per divider step
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // 1.0 in Q1.16
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [15:0] RST_INITIAL_RIGHT = 16'd32833;
    localparam logic [15:0] RST_INITIAL_LEFT  = 16'd32833;
    localparam logic [15:0] RST_SOFT_RIGHT    = 16'd52429;
    localparam logic [15:0] RST_SOFT_LEFT     = 16'd52429;
    localparam logic [15:0] RST_HARD_RIGHT    = 16'd58982;
    localparam logic [15:0] RST_HARD_LEFT     = 16'd58982;
    localparam logic [15:0] RST_BAR_STEP      = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_RIGHT = 3'd0,
        CFG_INITIAL_LEFT  = 3'd1,
        CFG_SOFT_RIGHT    = 3'd2,
        CFG_SOFT_LEFT     = 3'd3,
        CFG_HARD_RIGHT    = 3'd4,
        CFG_HARD_LEFT     = 3'd5,
        CFG_BAR_STEP      = 3'd6,
        CFG_DISCRETE_MODE = 3'd7
    } ptd_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_WRITE
    } ptd_state_t;

    // how drive and turn are formed at the end of an item
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_RIGHT,
        KIND_LEFT
    } ptd_kind_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_step;
        logic write_out;
    } ptd_cmd_t;

    typedef struct packed {
        logic out_free;
    } ptd_sts_t;

endpackage

@@ hw/rtl/ptd_div.sv @@
// iterative restoring divider lane: num*65536/den, truncated, clamped to +-1.0
module ptd_div (
    input  logic                             aclk,
    input  logic                             start,
    input  logic                             step,
    input  logic signed [ptd_pkg::TURN_W-1:0] num,
    input  logic signed [ptd_pkg::TURN_W-1:0] den,
    output logic signed [ptd_pkg::TURN_W-1:0] ratio
);
    import ptd_pkg::*;

    logic signed [TURN_W-1:0] num_inv;
    logic signed [TURN_W-1:0] den_inv;
    logic [16:0]              num_mag;
    logic [15:0]              den_mag;
    logic [16:0]              trial;
    logic                     fits;
    logic [16:0]              mag;

    logic [15:0] rem_reg,  rem_next;
    logic [15:0] quot_reg, quot_next;
    logic [15:0] den_reg,  den_next;
    logic        sat_reg,  sat_next;
    logic        zero_reg, zero_next;
    logic        neg_reg,  neg_next;

    always_comb begin
        num_inv = -num;
        den_inv = -den;
        num_mag = num[TURN_W-1] ? num_inv[16:0] : num[16:0];
        den_mag = den[TURN_W-1] ? den_inv[15:0] : den[15:0];

        trial = {rem_reg, 1'b0};
        fits  = trial >= {1'b0, den_reg};

        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        sat_next  = sat_reg;
        zero_next = zero_reg;
        neg_next  = neg_reg;
        if (start) begin
            // a ratio of one or more saturates, so only a 16-bit quotient is needed
            rem_next  = num_mag[15:0];
            quot_next = '0;
            den_next  = den_mag;
            sat_next  = num_mag >= {1'b0, den_mag};
            zero_next = den_mag == '0;
            neg_next  = num[TURN_W-1] ^ den[TURN_W-1];
        end else if (step) begin
            rem_next  = fits ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            quot_next = {quot_reg[14:0], fits};
        end

        if (zero_reg) begin
            mag = '0;
        end else if (sat_reg) begin
            mag = ONE_Q16;
        end else begin
            mag = {1'b0, quot_reg};
        end
        ratio = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        sat_reg  <= sat_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
    end

endmodule

@@ hw/rtl/ptd_datapath.sv @@
// datapath: config registers, band decode, dwell bars, two divider lanes, result register
module ptd_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ptd_pkg::ptd_cmd_t                 cmd,
    output ptd_pkg::ptd_sts_t                 sts,
    input  logic [ptd_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ptd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser
);
    import ptd_pkg::*;

    // configuration
    logic [15:0] ir_reg, il_reg, sr_reg, sl_reg, hr_reg, hl_reg, step_reg;
    logic        disc_reg;

    // item and state
    logic [PROB_W-1:0]  p_reg;
    logic               match_reg;
    logic [LEVEL_W-1:0] rbar_reg, rbar_next;
    logic [LEVEL_W-1:0] lbar_reg, lbar_next;
    ptd_kind_t          kind_reg, kind_next;
    logic               valid_reg, valid_next;
    logic               fired_reg, fired_next;
    logic               id_reg, id_next;

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic [16:0] p17, q17, sum_hl, sum_il;
    logic        active, in_band, init_band, right_of_init, left_of_init;
    logic        above_hard, below_hard, charge_r, charge_l;
    logic [16:0] r_sum, l_sum, dec;
    logic [15:0] r_chg, l_chg;
    logic signed [TURN_W-1:0] d_num, d_den, t_num, t_den;
    logic signed [TURN_W-1:0] d_ratio, t_ratio;
    logic [DRIVE_W-1:0]       drive;
    logic signed [TURN_W-1:0] turn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ir_reg   <= RST_INITIAL_RIGHT;
            il_reg   <= RST_INITIAL_LEFT;
            sr_reg   <= RST_SOFT_RIGHT;
            sl_reg   <= RST_SOFT_LEFT;
            hr_reg   <= RST_HARD_RIGHT;
            hl_reg   <= RST_HARD_LEFT;
            step_reg <= RST_BAR_STEP;
            disc_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (ptd_cfg_idx_t'(cfg_index))
                CFG_INITIAL_RIGHT: ir_reg   <= cfg_data;
                CFG_INITIAL_LEFT:  il_reg   <= cfg_data;
                CFG_SOFT_RIGHT:    sr_reg   <= cfg_data;
                CFG_SOFT_LEFT:     sl_reg   <= cfg_data;
                CFG_HARD_RIGHT:    hr_reg   <= cfg_data;
                CFG_HARD_LEFT:     hl_reg   <= cfg_data;
                CFG_BAR_STEP:      step_reg <= cfg_data;
                CFG_DISCRETE_MODE: disc_reg <= cfg_data[0];
            endcase
        end
    end

    always_comb begin
        p17    = {1'b0, p_reg};
        q17    = ONE_Q16 - p17;
        sum_hl = p17 + {1'b0, hl_reg};
        sum_il = p17 + {1'b0, il_reg};

        active        = !disc_reg && match_reg;
        in_band       = (p_reg < hr_reg) && (sum_hl > ONE_Q16);
        init_band     = (p_reg < ir_reg) && (sum_il > ONE_Q16);
        right_of_init = p_reg > ir_reg;
        left_of_init  = sum_il < ONE_Q16;
        above_hard    = p_reg > hr_reg;
        below_hard    = sum_hl < ONE_Q16;

        // numerators and denominators for the side of the initial band p lies on
        if (right_of_init) begin
            d_num = $signed({2'b00, sr_reg}) - $signed({2'b00, p_reg});
            d_den = $signed({2'b00, sr_reg}) - $signed({2'b00, ir_reg});
            t_num = $signed({2'b00, ir_reg}) - $signed({2'b00, p_reg});
            t_den = $signed({2'b00, ir_reg}) - $signed({2'b00, hr_reg});
        end else begin
            d_num = $signed({2'b00, sl_reg}) - $signed({1'b0, q17});
            d_den = $signed({2'b00, sl_reg}) - $signed({2'b00, il_reg});
            t_num = $signed({2'b00, il_reg}) - $signed({1'b0, q17});
            t_den = $signed({2'b00, il_reg}) - $signed({2'b00, hl_reg});
        end

        priority if (!in_band) begin
            kind_next = KIND_ZERO;
        end else if (init_band) begin
            kind_next = KIND_FULL;
        end else if (right_of_init) begin
            kind_next = KIND_RIGHT;
        end else if (left_of_init) begin
            kind_next = KIND_LEFT;
        end else begin
            kind_next = KIND_ZERO;
        end

        charge_r = !in_band && above_hard;
        charge_l = !in_band && !above_hard && below_hard;

        r_sum = {1'b0, rbar_reg} + {1'b0, step_reg};
        l_sum = {1'b0, lbar_reg} + {1'b0, step_reg};
        r_chg = charge_r ? (r_sum[16] ? '0 : r_sum[15:0]) : rbar_reg;
        l_chg = charge_l ? (l_sum[16] ? '0 : l_sum[15:0]) : lbar_reg;

        // decay by a quarter step, floor at zero
        dec = {3'b000, step_reg[15:2]};
        rbar_next = rbar_reg;
        lbar_next = lbar_reg;
        if (active) begin
            rbar_next = ({1'b0, r_chg} > dec) ? 16'({1'b0, r_chg} - dec) : '0;
            lbar_next = ({1'b0, l_chg} > dec) ? 16'({1'b0, l_chg} - dec) : '0;
        end

        valid_next = active && (in_band || above_hard || below_hard);
        fired_next = active && ((charge_r && r_sum[16]) || (charge_l && l_sum[16]));
        id_next    = active && charge_l && l_sum[16];

        unique case (kind_reg)
            KIND_FULL:            drive = ONE_Q16;
            KIND_RIGHT,
            KIND_LEFT:            drive = d_ratio[TURN_W-1] ? '0 : d_ratio[DRIVE_W-1:0];
            KIND_ZERO:            drive = '0;
        endcase
        unique case (kind_reg)
            KIND_RIGHT:           turn = t_ratio;
            KIND_LEFT:            turn = -t_ratio;
            KIND_FULL, KIND_ZERO: turn = '0;
        endcase
    end

    ptd_div u_div_drive (
        .aclk  (aclk),
        .start (cmd.eval),
        .step  (cmd.div_step),
        .num   (d_num),
        .den   (d_den),
        .ratio (d_ratio)
    );

    ptd_div u_div_turn (
        .aclk  (aclk),
        .start (cmd.eval),
        .step  (cmd.div_step),
        .num   (t_num),
        .den   (t_den),
        .ratio (t_ratio)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rbar_reg <= '0;
            lbar_reg <= '0;
            kind_reg <= KIND_ZERO;
        end else if (cmd.eval) begin
            rbar_reg <= rbar_next;
            lbar_reg <= lbar_next;
            // a rejected item forms no command
            kind_reg <= active ? kind_next : KIND_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            p_reg     <= s_tdata[PROB_W-1:0];
            match_reg <= s_tuser;
        end
        if (cmd.eval) begin
            valid_reg <= valid_next;
            fired_reg <= fired_next;
            id_reg    <= id_next;
        end
        if (cmd.write_out) begin
            m_tdata_reg <= {3'b000, id_reg, fired_reg, lbar_reg, rbar_reg, turn, drive};
            m_tuser_reg <= valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.write_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;

endmodule

@@ hw/rtl/ptd_ctrl.sv @@
// controller: sequences accept, evaluate, divide and result write
module ptd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ptd_pkg::ptd_sts_t sts,
    output ptd_pkg::ptd_cmd_t cmd
);
    import ptd_pkg::*;

    ptd_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (sts.out_free) begin
                    cmd.write_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

endmodule

@@ hw/rtl/probability_to_drive_with_dwell_bars.sv @@
// top level: probability to drive and turn with two dwell bars
// after the input transfer an item passes the evaluate, divide and write states; the write waits for a free result slot
// one item at a time: a new input is taken only after the last result is written; 16-step radix-2 divider (two lanes)
// the result register lets the next input transfer happen while a result waits
// reset: synchronous active-low aresetn loads register defaults, clears both bars
// and the output valid; configuration writes are taken in every cycle outside reset
module probability_to_drive_with_dwell_bars (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptd_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] probability
    input  logic                              s_tuser,   // [0] classes_match
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [16:0] drive, [34:17] turn, [50:35] right_level, [66:51] left_level,
    // [67] button_fired, [68] fired button side (0 right, 1 left), [71:69] zero
    output logic [ptd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser,   // [0] command_valid
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ptd_pkg::*;

    ptd_cmd_t cmd;
    ptd_sts_t sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: idle, evaluate, sixteen divide steps, write result
    ptd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // band decode, bar update, divider lanes and result register
    ptd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hw/rtl/ptd_checker.sv @@
// port-level checker for the probability-to-drive block, bound to the top level
module ptd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import ptd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // one item at a time: an input transfer closes the input side next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // no command means zero drive and zero turn
    a_no_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[34:0] == '0)
        else $error("drive or turn set without a command");

    // a button fires only on a valid command, and the id is zero without a button
    a_button: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[67] || m_tuser) && (m_tdata[67] || !m_tdata[68]))
        else $error("button flags inconsistent");

endmodule

bind probability_to_drive_with_dwell_bars ptd_checker u_ptd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
